/* rtl/usri_pkg.sv */
// Shared types for the unit sphere ray intersection pipeline.
// No dependencies; imported by every module of the block.
package usri_pkg;

   // Per-stage control handed down into the pipelined sub-units.
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

endpackage

/* rtl/unit_sphere_ray_intersect.sv */
// Unit sphere ray intersection in fixed point: one request per clock unless stalled.
// Fully pipelined; the square root produces one root bit per stage and the divider one
// quotient bit per stage, and those two chains set the depth. A new request enters every
// cycle; the whole pipeline holds only while the output register carries a result that
// is stalled. Depends on usri_pkg, usri_sqrt and usri_div.
module unit_sphere_ray_intersect #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [WORD_WIDTH-1:0] req_origin_x,
   input  logic signed [WORD_WIDTH-1:0] req_origin_y,
   input  logic signed [WORD_WIDTH-1:0] req_origin_z,
   input  logic signed [WORD_WIDTH-1:0] req_dir_x,
   input  logic signed [WORD_WIDTH-1:0] req_dir_y,
   input  logic signed [WORD_WIDTH-1:0] req_dir_z,
   input  logic signed [WORD_WIDTH-1:0] req_range_min,
   input  logic signed [WORD_WIDTH-1:0] req_range_max,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic signed [WORD_WIDTH-1:0] rsp_new_range_max,
   output logic signed [WORD_WIDTH-1:0] rsp_point_x,
   output logic signed [WORD_WIDTH-1:0] rsp_point_y,
   output logic signed [WORD_WIDTH-1:0] rsp_point_z
);
   import usri_pkg::*;

   localparam int W    = WORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int AW   = 2 * W;           // products and squared lengths
   localparam int MW   = 2 * W + 1;       // signed sums of products
   localparam int PW   = 4 * W;           // products of sums
   localparam int DW   = 4 * W + 2;       // discriminant, signed
   localparam int RW   = DW + 2 * F;      // radicand
   localparam int SW   = RW / 2;          // root
   localparam int QW   = 2 * W + F + 2;   // numerator magnitude and quotient
   localparam int NW   = QW + 1;          // signed numerator
   localparam int TW   = QW + 2;          // signed root distance
   localparam int SUMW = 2 * W - F + 1;   // hit point before saturation

   localparam logic signed [MW-1:0]   ONE_SQ = MW'(1) <<< (2 * F);
   localparam logic signed [SUMW-1:0] SAT_HI = SUMW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

   typedef struct packed {
      logic [2:0][W-1:0] e;
      logic [2:0][W-1:0] d;
      logic signed [W-1:0] tmin;
      logic signed [W-1:0] tmax;
   } ray_type;

   typedef struct packed {
      ray_type            ray;
      logic [AW-1:0]      d2;
      logic signed [MW-1:0] de;
      logic               cand;
   } sq_tag_type;

   typedef struct packed {
      ray_type ray;
      logic    cand;
      logic    xneg;
   } dv_tag_type;

   logic         advance;
   pipe_ctl_type sq_ctl, dv_ctl;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // stage 0: capture request
   ray_type s0_ff;
   logic    v0_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff.e    <= {req_origin_z, req_origin_y, req_origin_x};
         s0_ff.d    <= {req_dir_z, req_dir_y, req_dir_x};
         s0_ff.tmin <= req_range_min;
         s0_ff.tmax <= req_range_max;
      end
   end

   // stage 1: per-axis products
   ray_type              s1_ff;
   logic                 v1_ff;
   logic signed [AW-1:0] pe_in [3], pd_in [3], px_in [3];
   logic signed [AW-1:0] pe_ff [3], pd_ff [3], px_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pe_in[i] = $signed(s0_ff.e[i]) * $signed(s0_ff.e[i]);
         pd_in[i] = $signed(s0_ff.d[i]) * $signed(s0_ff.d[i]);
         px_in[i] = $signed(s0_ff.d[i]) * $signed(s0_ff.e[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s0_ff;
         pe_ff <= pe_in;
         pd_ff <= pd_in;
         px_ff <= px_in;
      end
   end

   // stage 2: |e|^2 - 1, |d|^2, d.e
   ray_type              s2_ff;
   logic                 v2_ff;
   logic signed [MW-1:0] e2m1_in, e2m1_ff, de2_in, de2_ff;
   logic [AW-1:0]        d2_in, d2_2_ff;

   always_comb begin
      e2m1_in = MW'(pe_ff[0]) + MW'(pe_ff[1]) + MW'(pe_ff[2]) - ONE_SQ;
      d2_in   = pd_ff[0] + pd_ff[1] + pd_ff[2];
      de2_in  = MW'(px_ff[0]) + MW'(px_ff[1]) + MW'(px_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff   <= s1_ff;
         e2m1_ff <= e2m1_in;
         d2_2_ff <= d2_in;
         de2_ff  <= de2_in;
      end
   end

   // stage 3: split the two wide products into word-sized partials
   ray_type              s3_ff;
   logic                 v3_ff;
   logic [AW-1:0]        de_mag, e2_mag;
   logic [AW-1:0]        sqhh_ff, sqhl_ff, sqll_ff;
   logic [AW-1:0]        prhh_ff, prhl_ff, prlh_ff, prll_ff;
   logic [AW-1:0]        d2_3_ff;
   logic signed [MW-1:0] de3_ff;
   logic                 e2neg_ff;

   always_comb begin
      de_mag = de2_ff[MW-1] ? AW'(-de2_ff) : AW'(de2_ff);
      e2_mag = e2m1_ff[MW-1] ? AW'(-e2m1_ff) : AW'(e2m1_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff    <= s2_ff;
         sqhh_ff  <= de_mag[AW-1:W] * de_mag[AW-1:W];
         sqhl_ff  <= de_mag[AW-1:W] * de_mag[W-1:0];
         sqll_ff  <= de_mag[W-1:0] * de_mag[W-1:0];
         prhh_ff  <= d2_2_ff[AW-1:W] * e2_mag[AW-1:W];
         prhl_ff  <= d2_2_ff[AW-1:W] * e2_mag[W-1:0];
         prlh_ff  <= d2_2_ff[W-1:0] * e2_mag[AW-1:W];
         prll_ff  <= d2_2_ff[W-1:0] * e2_mag[W-1:0];
         d2_3_ff  <= d2_2_ff;
         de3_ff   <= de2_ff;
         e2neg_ff <= e2m1_ff[MW-1];
      end
   end

   // stage 4: recombine partials
   ray_type              s4_ff;
   logic                 v4_ff;
   logic [PW-1:0]        sq_ff, pr_ff;
   logic [AW-1:0]        d2_4_ff;
   logic signed [MW-1:0] de4_ff;
   logic                 e2neg4_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_ff     <= s3_ff;
         sq_ff     <= (PW'(sqhh_ff) << (2 * W)) + (PW'(sqhl_ff) << (W + 1))
                      + PW'(sqll_ff);
         pr_ff     <= (PW'(prhh_ff) << (2 * W)) + (PW'(prhl_ff) << W)
                      + (PW'(prlh_ff) << W) + PW'(prll_ff);
         d2_4_ff   <= d2_3_ff;
         de4_ff    <= de3_ff;
         e2neg4_ff <= e2neg_ff;
      end
   end

   // stage 5: discriminant and radicand
   logic signed [DW-1:0] dlt;
   sq_tag_type           sq_tag_in, sq_tag_ff, sq_tag_out;
   logic [RW-1:0]        rad_ff;
   logic                 v5_ff;

   always_comb begin
      dlt = e2neg4_ff ? $signed(DW'(sq_ff)) + $signed(DW'(pr_ff))
                      : $signed(DW'(sq_ff)) - $signed(DW'(pr_ff));
      sq_tag_in.ray  = s4_ff;
      sq_tag_in.d2   = d2_4_ff;
      sq_tag_in.de   = de4_ff;
      sq_tag_in.cand = (d2_4_ff != '0) && !dlt[DW-1] && (dlt != '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_tag_ff <= sq_tag_in;
         rad_ff    <= {dlt, {(2 * F){1'b0}}};
      end
   end

   assign sq_ctl.advance = advance;
   assign sq_ctl.valid   = v5_ff;

   logic          sq_valid;
   logic [SW-1:0] root;

   usri_sqrt #(
      .RAD_W (RW),
      .TAG_W ($bits(sq_tag_type))
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sq_ctl),
      .rad     (rad_ff),
      .tag_i   (sq_tag_ff),
      .valid_o (sq_valid),
      .root_o  (root),
      .tag_o   (sq_tag_out)
   );

   // stage 6: numerator b*2^F + root, split into sign and magnitude
   logic signed [NW-1:0] num;
   dv_tag_type           dv_tag_ff, dv_tag_out;
   logic [QW-1:0]        mag_ff;
   logic [AW-1:0]        den_ff;
   logic                 v6_ff;

   assign num = ($signed(NW'(sq_tag_out.de)) <<< F) + $signed(NW'(root));

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff         <= num[NW-1] ? QW'(-num) : QW'(num);
         den_ff         <= sq_tag_out.d2;
         dv_tag_ff.ray  <= sq_tag_out.ray;
         dv_tag_ff.cand <= sq_tag_out.cand;
         dv_tag_ff.xneg <= !num[NW-1] && (num != '0);
      end
   end

   assign dv_ctl.advance = advance;
   assign dv_ctl.valid   = v6_ff;

   logic          dv_valid, rem_nz;
   logic [QW-1:0] quo;

   usri_div #(
      .NUM_W (QW),
      .DEN_W (AW),
      .TAG_W ($bits(dv_tag_type))
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dv_ctl),
      .num      (mag_ff),
      .den      (den_ff),
      .tag_i    (dv_tag_ff),
      .valid_o  (dv_valid),
      .quo_o    (quo),
      .rem_nz_o (rem_nz),
      .tag_o    (dv_tag_out)
   );

   // stage 7: floor of the signed quotient
   logic [TW-1:0]        tmag;
   logic signed [TW-1:0] t_ff;
   ray_type              s7_ff;
   logic                 cand7_ff, v7_ff;

   assign tmag = TW'(quo) + TW'(dv_tag_out.xneg && rem_nz);

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff     <= dv_tag_out.xneg ? $signed(-tmag) : $signed(tmag);
         s7_ff    <= dv_tag_out.ray;
         cand7_ff <= dv_tag_out.cand;
      end
   end

   // stage 8: interval test, bounds inclusive
   ray_type       s8_ff;
   logic          hit8_ff, v8_ff;
   logic [W-1:0]  tw8_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         hit8_ff <= cand7_ff && (t_ff >= TW'(s7_ff.tmin)) && (t_ff <= TW'(s7_ff.tmax));
         tw8_ff  <= t_ff[W-1:0];
         s8_ff   <= s7_ff;
      end
   end

   // stage 9: d * t per axis
   ray_type              s9_ff;
   logic                 hit9_ff, v9_ff;
   logic [W-1:0]         tw9_ff;
   logic signed [AW-1:0] dt_ff [3];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            dt_ff[i] <= $signed(s8_ff.d[i]) * $signed(tw8_ff);
         end
         hit9_ff <= hit8_ff;
         tw9_ff  <= tw8_ff;
         s9_ff   <= s8_ff;
      end
   end

   // output stage: e + d*t, saturated
   logic signed [SUMW-1:0] psum [3];
   logic signed [W-1:0]    psat [3];
   logic signed [AW-1:0]   dt_sh [3];
   logic                   out_vld_ff, hit_ff;
   logic signed [W-1:0]    nrm_ff;
   logic signed [W-1:0]    pt_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dt_sh[i] = dt_ff[i] >>> F;
         psum[i]  = SUMW'($signed(s9_ff.e[i])) + SUMW'(dt_sh[i]);
         if (psum[i] > SAT_HI) begin
            psat[i] = SAT_HI[W-1:0];
         end else if (psum[i] < SAT_LO) begin
            psat[i] = SAT_LO[W-1:0];
         end else begin
            psat[i] = psum[i][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff <= hit9_ff;
         nrm_ff <= hit9_ff ? $signed(tw9_ff) : s9_ff.tmax;
         for (int i = 0; i < 3; i++) begin
            pt_ff[i] <= hit9_ff ? psat[i] : '0;
         end
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff      <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         v5_ff      <= 1'b0;
         v6_ff      <= 1'b0;
         v7_ff      <= 1'b0;
         v8_ff      <= 1'b0;
         v9_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         v0_ff      <= req_valid;
         v1_ff      <= v0_ff;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         v5_ff      <= v4_ff;
         v6_ff      <= sq_valid;
         v7_ff      <= dv_valid;
         v8_ff      <= v7_ff;
         v9_ff      <= v8_ff;
         out_vld_ff <= v9_ff;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_new_range_max = nrm_ff;
   assign rsp_point_x       = pt_ff[0];
   assign rsp_point_y       = pt_ff[1];
   assign rsp_point_z       = pt_ff[2];

endmodule

/* rtl/usri_sqrt.sv */
// Pipelined floor square root, one result bit per register stage.
// Depends on usri_pkg for the pipeline control struct.
module usri_sqrt #(
   parameter int RAD_W = 164,
   parameter int TAG_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  usri_pkg::pipe_ctl_type  ctl,
   input  logic [RAD_W-1:0]        rad,
   input  logic [TAG_W-1:0]        tag_i,
   output logic                    valid_o,
   output logic [RAD_W/2-1:0]      root_o,
   output logic [TAG_W-1:0]        tag_o
);
   import usri_pkg::*;

   localparam int ROOT_W = RAD_W / 2;
   localparam int TRY_W  = ROOT_W + 4;

   logic [ROOT_W+1:0] stage_rem  [0:ROOT_W];
   logic [ROOT_W-1:0] stage_root [0:ROOT_W];
   logic [RAD_W-1:0]  stage_rad  [0:ROOT_W];
   logic [TAG_W-1:0]  stage_tag  [0:ROOT_W];
   logic              stage_vld  [0:ROOT_W];

   assign stage_rem[0]  = '0;
   assign stage_root[0] = '0;
   assign stage_rad[0]  = rad;
   assign stage_tag[0]  = tag_i;
   assign stage_vld[0]  = ctl.valid;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [TRY_W-1:0]  trial, sub, diff;
      logic              take;
      logic [ROOT_W+1:0] rem_in, rem_ff;
      logic [ROOT_W-1:0] root_in, root_ff;
      logic [RAD_W-1:0]  rad_ff;
      logic [TAG_W-1:0]  tag_ff;
      logic              vld_ff;

      // bring down the next radicand bit pair and try root*4+1
      assign trial   = {stage_rem[k], stage_rad[k][RAD_W-1 -: 2]};
      assign sub     = TRY_W'({stage_root[k], 2'b01});
      assign diff    = trial - sub;
      assign take    = (trial >= sub);
      assign rem_in  = take ? diff[ROOT_W+1:0] : trial[ROOT_W+1:0];
      assign root_in = {stage_root[k][ROOT_W-2:0], take};

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            rad_ff  <= stage_rad[k] << 2;
            tag_ff  <= stage_tag[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (ctl.advance) begin
            vld_ff <= stage_vld[k];
         end
      end

      assign stage_rem[k+1]  = rem_ff;
      assign stage_root[k+1] = root_ff;
      assign stage_rad[k+1]  = rad_ff;
      assign stage_tag[k+1]  = tag_ff;
      assign stage_vld[k+1]  = vld_ff;
   end

   assign valid_o = stage_vld[ROOT_W];
   assign root_o  = stage_root[ROOT_W];
   assign tag_o   = stage_tag[ROOT_W];

endmodule

/* rtl/usri_div.sv */
// Pipelined restoring unsigned divider, one quotient bit per register stage.
// Depends on usri_pkg for the pipeline control struct.
module usri_div #(
   parameter int NUM_W = 82,
   parameter int DEN_W = 64,
   parameter int TAG_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  usri_pkg::pipe_ctl_type  ctl,
   input  logic [NUM_W-1:0]        num,
   input  logic [DEN_W-1:0]        den,
   input  logic [TAG_W-1:0]        tag_i,
   output logic                    valid_o,
   output logic [NUM_W-1:0]        quo_o,
   output logic                    rem_nz_o,
   output logic [TAG_W-1:0]        tag_o
);
   import usri_pkg::*;

   logic [DEN_W-1:0] stage_rem [0:NUM_W];
   logic [NUM_W-1:0] stage_num [0:NUM_W];
   logic [NUM_W-1:0] stage_quo [0:NUM_W];
   logic [DEN_W-1:0] stage_den [0:NUM_W];
   logic [TAG_W-1:0] stage_tag [0:NUM_W];
   logic             stage_vld [0:NUM_W];

   assign stage_rem[0] = '0;
   assign stage_num[0] = num;
   assign stage_quo[0] = '0;
   assign stage_den[0] = den;
   assign stage_tag[0] = tag_i;
   assign stage_vld[0] = ctl.valid;

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0]   trial, diff;
      logic             take;
      logic [DEN_W-1:0] rem_in, rem_ff, den_ff;
      logic [NUM_W-1:0] num_ff, quo_ff;
      logic [TAG_W-1:0] tag_ff;
      logic             vld_ff;

      assign trial  = {stage_rem[k], stage_num[k][NUM_W-1]};
      assign take   = (trial >= {1'b0, stage_den[k]});
      assign diff   = trial - {1'b0, stage_den[k]};
      assign rem_in = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            rem_ff <= rem_in;
            num_ff <= stage_num[k] << 1;
            quo_ff <= {stage_quo[k][NUM_W-2:0], take};
            den_ff <= stage_den[k];
            tag_ff <= stage_tag[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (ctl.advance) begin
            vld_ff <= stage_vld[k];
         end
      end

      assign stage_rem[k+1] = rem_ff;
      assign stage_num[k+1] = num_ff;
      assign stage_quo[k+1] = quo_ff;
      assign stage_den[k+1] = den_ff;
      assign stage_tag[k+1] = tag_ff;
      assign stage_vld[k+1] = vld_ff;
   end

   assign valid_o  = stage_vld[NUM_W];
   assign quo_o    = stage_quo[NUM_W];
   assign rem_nz_o = |stage_rem[NUM_W];
   assign tag_o    = stage_tag[NUM_W];

endmodule
